[src/bir_pkg.sv]
// ----------------------------------------------------------------------------
// bir_pkg
// Shared types, widths and codes of the bilinear image resampler.
// ----------------------------------------------------------------------------
`default_nettype none

package bir_pkg;

  localparam int DIM_W   = 9;
  localparam int STEP_W  = 20;
  localparam int COORD_W = 12;
  localparam int ADDR_W  = 16;
  localparam int CH_W    = 8;
  localparam int FRAC_W  = 16;
  localparam int POS_W   = COORD_W + STEP_W;
  localparam int ONE_W   = FRAC_W + 1;
  localparam int WGT_W   = 2 * FRAC_W + 1;
  localparam int ACC_W   = WGT_W + CH_W;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W   = STEP_W;

  localparam logic [DIM_W-1:0] MAX_WIDTH  = DIM_W'(256);
  localparam logic [DIM_W-1:0] MAX_HEIGHT = DIM_W'(256);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SOURCE_WIDTH  = 2'd0,
    REG_SOURCE_HEIGHT = 2'd1,
    REG_X_STEP        = 2'd2,
    REG_Y_STEP        = 2'd3
  } cfg_reg_e;

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_SAMPLE = 1'b1
  } opcode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADDR,
    ST_RD0,
    ST_RD1,
    ST_RD2,
    ST_RD3,
    ST_ACC
  } state_e;

  typedef struct packed {
    logic [ADDR_W-1:0] row1;
    logic [ADDR_W-1:0] row2;
    logic [DIM_W-1:0]  x1;
    logic [DIM_W-1:0]  x2;
    logic [WGT_W-1:0]  w1;
    logic [WGT_W-1:0]  w2;
    logic [WGT_W-1:0]  w3;
    logic [WGT_W-1:0]  w4;
  } coord_t;

  typedef struct packed {
    logic       acc_en;
    logic       done_en;
    logic [1:0] wsel;
  } blend_ctl_t;

  function automatic logic [DIM_W-1:0] eff_dim(logic [DIM_W-1:0] v, logic [DIM_W-1:0] m);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > m) begin
      r = m;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[src/bilinear_image_resampler.sv]
// ----------------------------------------------------------------------------
// bilinear_image_resampler
// RGB frame store with bilinear sampling at scaled output coordinates.
// ----------------------------------------------------------------------------
// Load request: written to the frame store at acceptance.
// Sample request: the position is taken at acceptance, then the address stage,
//   four reads of the single-port frame store and the blend step, which waits
//   for a free result register; the next request is taken back in idle.
// Reset clears control state and sets the registers to 256, 256, 0.5, 0.5.
// The frame store is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module bilinear_image_resampler
  import bir_pkg::*;
#(
  parameter int CHANNELS = 3
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i,
  input  wire logic                 s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  // pixel_index, out_col, out_row, load_red, load_green, load_blue
  input  wire logic [63:0]          s_axis_tdata_i,
  // opcode
  input  wire logic [0:0]           s_axis_tuser_i,
  output logic                      m_axis_tvalid_o,
  input  wire logic                 m_axis_tready_i,
  // out_red, out_green, out_blue
  output logic      [23:0]          m_axis_tdata_o
);

  localparam int PIX_W = CH_W * CHANNELS;

  state_e            state_q, state_d;
  logic [DIM_W-1:0]  width_q, height_q;
  logic [STEP_W-1:0] x_step_q, y_step_q;

  logic              in_acc, is_sample;
  logic              mem_we, mem_re, addr_en, free;
  logic [ADDR_W-1:0] mem_addr, rd_addr;
  logic [PIX_W-1:0]  rdata;
  coord_t            coord;
  blend_ctl_t        bctl;

  assign in_acc    = s_axis_tvalid_i && s_axis_tready_o;
  assign is_sample = opcode_e'(s_axis_tuser_i[0]) == OP_SAMPLE;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DIM_W'(256);
      height_q <= DIM_W'(256);
      x_step_q <= STEP_W'(32768);
      y_step_q <= STEP_W'(32768);
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_SOURCE_WIDTH:  width_q  <= cfg_data_i[DIM_W-1:0];
        REG_SOURCE_HEIGHT: height_q <= cfg_data_i[DIM_W-1:0];
        REG_X_STEP:        x_step_q <= cfg_data_i;
        REG_Y_STEP:        y_step_q <= cfg_data_i;
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_acc && is_sample) state_d = ST_ADDR;
      ST_ADDR: state_d = ST_RD0;
      ST_RD0:  state_d = ST_RD1;
      ST_RD1:  state_d = ST_RD2;
      ST_RD2:  state_d = ST_RD3;
      ST_RD3:  state_d = ST_ACC;
      ST_ACC:  if (free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    s_axis_tready_o = 1'b0;
    addr_en         = 1'b0;
    mem_re          = 1'b0;
    rd_addr         = coord.row1 + ADDR_W'(coord.x1);
    bctl            = '0;
    unique case (state_q)
      ST_IDLE: s_axis_tready_o = 1'b1;
      ST_ADDR: addr_en = 1'b1;
      ST_RD0: begin
        mem_re  = 1'b1;
      end
      ST_RD1: begin
        mem_re      = 1'b1;
        rd_addr     = coord.row1 + ADDR_W'(coord.x2);
        bctl.acc_en = 1'b1;
        bctl.wsel   = 2'd0;
      end
      ST_RD2: begin
        mem_re      = 1'b1;
        rd_addr     = coord.row2 + ADDR_W'(coord.x1);
        bctl.acc_en = 1'b1;
        bctl.wsel   = 2'd1;
      end
      ST_RD3: begin
        mem_re      = 1'b1;
        rd_addr     = coord.row2 + ADDR_W'(coord.x2);
        bctl.acc_en = 1'b1;
        bctl.wsel   = 2'd2;
      end
      ST_ACC: begin
        bctl.done_en = free;
        bctl.wsel    = 2'd3;
      end
      default: s_axis_tready_o = 1'b0;
    endcase
  end

  assign mem_we   = in_acc && !is_sample;
  assign mem_addr = mem_we ? s_axis_tdata_i[ADDR_W-1:0] : rd_addr;

  bir_frame_mem #(
    .DATA_W (PIX_W)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .re_i    (mem_re),
    .addr_i  (mem_addr),
    .wdata_i (s_axis_tdata_i[40 +: PIX_W]),
    .rdata_o (rdata)
  );

  bir_coord u_coord (
    .clk_i     (clk_i),
    .mul_en_i  (in_acc && is_sample),
    .addr_en_i (addr_en),
    .col_i     (s_axis_tdata_i[27:16]),
    .row_i     (s_axis_tdata_i[39:28]),
    .x_step_i  (x_step_q),
    .y_step_i  (y_step_q),
    .width_i   (width_q),
    .height_i  (height_q),
    .coord_o   (coord)
  );

  bir_blend #(
    .CHANNELS (CHANNELS)
  ) u_blend (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (bctl),
    .coord_i  (coord),
    .pix_i    (rdata),
    .tdata_o  (m_axis_tdata_o),
    .tvalid_o (m_axis_tvalid_o),
    .tready_i (m_axis_tready_i),
    .free_o   (free)
  );

  a_sample_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && is_sample) |=> (state_q == ST_ADDR))
    else $error("accepted sample did not start address stage");

  a_result_after_blend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(state_q == ST_ACC))
    else $error("result appeared outside the blend step");

  a_single_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we && mem_re))
    else $error("frame store read and written in one cycle");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> $stable(m_axis_tdata_o))
    else $error("pending result overwritten");

endmodule

`default_nettype wire

[src/bir_frame_mem.sv]
// ----------------------------------------------------------------------------
// bir_frame_mem
// Single-port frame store, one access a cycle, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bir_frame_mem
  import bir_pkg::*;
#(
  parameter int DATA_W = 24
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] addr_i,
  input  wire logic [DATA_W-1:0] wdata_i,
  output logic      [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[addr_i];
    end
  end

endmodule

`default_nettype wire

[src/bir_coord.sv]
// ----------------------------------------------------------------------------
// bir_coord
// Source position, neighbour clamp, row bases and bilinear weights.
// ----------------------------------------------------------------------------
`default_nettype none

module bir_coord
  import bir_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               mul_en_i,
  input  wire logic               addr_en_i,
  input  wire logic [COORD_W-1:0] col_i,
  input  wire logic [COORD_W-1:0] row_i,
  input  wire logic [STEP_W-1:0]  x_step_i,
  input  wire logic [STEP_W-1:0]  y_step_i,
  input  wire logic [DIM_W-1:0]   width_i,
  input  wire logic [DIM_W-1:0]   height_i,
  output coord_t                  coord_o
);

  logic [POS_W-1:0] fx_q, fy_q;
  coord_t           coord_d, coord_q;

  logic [DIM_W-1:0]       w_eff, h_eff, w_m1, h_m1;
  logic [POS_W-FRAC_W-1:0] xi, yi;
  logic [DIM_W-1:0]       x1, y1, x2, y2;
  logic [FRAC_W-1:0]      dx, dy;
  logic [ONE_W-1:0]       ndx, ndy, dxe, dye;
  logic [2*DIM_W-1:0]     r1, r2;
  logic [2*ONE_W-1:0]     p1, p2, p3, p4;

  always_ff @(posedge clk_i) begin
    if (mul_en_i) begin
      fx_q <= POS_W'(col_i) * POS_W'(x_step_i);
      fy_q <= POS_W'(row_i) * POS_W'(y_step_i);
    end
  end

  always_comb begin
    w_eff = eff_dim(width_i, MAX_WIDTH);
    h_eff = eff_dim(height_i, MAX_HEIGHT);
    w_m1  = w_eff - DIM_W'(1);
    h_m1  = h_eff - DIM_W'(1);
    xi    = fx_q[POS_W-1:FRAC_W];
    yi    = fy_q[POS_W-1:FRAC_W];
    dx    = fx_q[FRAC_W-1:0];
    dy    = fy_q[FRAC_W-1:0];
    x1    = (xi > (POS_W-FRAC_W)'(w_m1)) ? w_m1 : xi[DIM_W-1:0];
    y1    = (yi > (POS_W-FRAC_W)'(h_m1)) ? h_m1 : yi[DIM_W-1:0];
    x2    = (({1'b0, x1} + (DIM_W+1)'(1)) < {1'b0, w_eff}) ? x1 + DIM_W'(1) : x1;
    y2    = (({1'b0, y1} + (DIM_W+1)'(1)) < {1'b0, h_eff}) ? y1 + DIM_W'(1) : y1;
    r1    = (2*DIM_W)'(y1) * (2*DIM_W)'(w_eff);
    r2    = (2*DIM_W)'(y2) * (2*DIM_W)'(w_eff);
    dxe   = {1'b0, dx};
    dye   = {1'b0, dy};
    ndx   = {1'b1, {FRAC_W{1'b0}}} - dxe;
    ndy   = {1'b1, {FRAC_W{1'b0}}} - dye;
    p1    = (2*ONE_W)'(ndx) * (2*ONE_W)'(ndy);
    p2    = (2*ONE_W)'(dxe) * (2*ONE_W)'(ndy);
    p3    = (2*ONE_W)'(ndx) * (2*ONE_W)'(dye);
    p4    = (2*ONE_W)'(dxe) * (2*ONE_W)'(dye);
    coord_d.row1 = r1[ADDR_W-1:0];
    coord_d.row2 = r2[ADDR_W-1:0];
    coord_d.x1   = x1;
    coord_d.x2   = x2;
    coord_d.w1   = p1[WGT_W-1:0];
    coord_d.w2   = p2[WGT_W-1:0];
    coord_d.w3   = p3[WGT_W-1:0];
    coord_d.w4   = p4[WGT_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (addr_en_i) begin
      coord_q <= coord_d;
    end
  end

  assign coord_o = coord_q;

endmodule

`default_nettype wire

[src/bir_blend.sv]
// ----------------------------------------------------------------------------
// bir_blend
// Weighted accumulation of four neighbours and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module bir_blend
  import bir_pkg::*;
#(
  parameter int CHANNELS = 3
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire blend_ctl_t               ctl_i,
  input  wire coord_t                   coord_i,
  input  wire logic [CH_W*CHANNELS-1:0] pix_i,
  output logic      [3*CH_W-1:0]        tdata_o,
  output logic                          tvalid_o,
  input  wire logic                     tready_i,
  output logic                          free_o
);

  logic             valid_q, valid_d;
  logic [WGT_W-1:0] wgt;

  always_comb begin
    case (ctl_i.wsel)
      2'd0:    wgt = coord_i.w1;
      2'd1:    wgt = coord_i.w2;
      2'd2:    wgt = coord_i.w3;
      default: wgt = coord_i.w4;
    endcase
  end

  for (genvar c = 0; c < 3; c++) begin : g_chan
    if (c < CHANNELS) begin : g_used
      logic [ACC_W-1:0] acc_q, acc_d, prod, fin;
      logic [CH_W-1:0]  data_q;

      always_comb begin
        prod  = ACC_W'(pix_i[CH_W*c +: CH_W]) * ACC_W'(wgt);
        acc_d = ((ctl_i.wsel == 2'd0) ? '0 : acc_q) + prod;
        fin   = acc_q + prod;
      end

      always_ff @(posedge clk_i) begin
        if (ctl_i.acc_en) begin
          acc_q <= acc_d;
        end
        if (ctl_i.done_en) begin
          data_q <= fin[2*FRAC_W +: CH_W];
        end
      end

      assign tdata_o[CH_W*c +: CH_W] = data_q;
    end else begin : g_unused
      assign tdata_o[CH_W*c +: CH_W] = '0;
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (ctl_i.done_en) begin
      valid_d = 1'b1;
    end else if (tready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign tvalid_o = valid_q;
  assign free_o   = !valid_q || tready_i;

endmodule

`default_nettype wire
